// ===== rtl/wrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrhp_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wrhp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] TAG_CUE  = 32'h2065_7563;

   localparam logic [1:0] EV_FMT    = 2'd0;
   localparam logic [1:0] EV_DATA   = 2'd1;
   localparam logic [1:0] EV_CUE    = 2'd2;
   localparam logic [1:0] EV_FINISH = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_RIFF  = 2'd1;
   localparam logic [1:0] ST_NOT_WAVE  = 2'd2;
   localparam logic [1:0] ST_MISSING   = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
      logic [31:0] header_length;
      logic [31:0] cue_offset;
      logic [5:0]  cue_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/wrhp_divider.sv =====
// ----------------------------------------------------------------------------
// wrhp_divider
// Restoring divider, 32-bit dividend by nonzero 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wrhp_divider
   import wrhp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic        busy_ff, busy_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;
   logic        qbit;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      trial    = {rem_ff, dvd_ff[31]};
      qbit     = (trial >= {1'b0, dvs_ff});
      if (busy_ff) begin
         // dividend shifts out at the top while quotient bits fill from below
         rem_in   = qbit ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         dvd_in   = {dvd_ff[30:0], qbit};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end else if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = div_req.dividend;
         rem_in   = '0;
         dvs_in   = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = busy_ff && (count_ff == 5'd31);
   assign div_rsp.quotient = {dvd_ff[30:0], qbit};

endmodule

`default_nettype wire

// ===== rtl/wrhp_queue.sv =====
// ----------------------------------------------------------------------------
// wrhp_queue
// Two-entry result queue between the parser front and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wrhp_queue
   import wrhp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   rsp_type    mem [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign rsp_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("push lost");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("pop lost");

endmodule

`default_nettype wire

// ===== rtl/wrhp_front.sv =====
// ----------------------------------------------------------------------------
// wrhp_front
// Byte parser: tag checks, chunk walk, field extraction, result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module wrhp_front
   import wrhp_pkg::*;
#(
   parameter int MAX_CUES = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        queue_full,
   output logic             push,
   output rsp_type          push_data,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp
);

   typedef enum logic [3:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE,
      PH_FMT, PH_CUEN, PH_CUEP, PH_SKIP, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] acc_ff, acc_in;
   logic [32:0] left_ff, left_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic        data_seen_ff, data_seen_in;
   logic [15:0] afmt_ff, afmt_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] srate_ff, srate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] balign_ff, balign_in;
   logic [15:0] bps_ff, bps_in;
   logic [31:0] dlen_ff, dlen_in;
   logic [31:0] sos_ff, sos_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] deflimit_ff, deflimit_in;
   logic [5:0]  pleft_ff, pleft_in;
   logic [4:0]  idx_ff, idx_in;
   logic [5:0]  accepted_ff, accepted_in;

   logic        accept;
   logic [31:0] placed;
   logic [31:0] accb;
   logic        fin;
   logic [1:0]  fin_status;
   logic        emit;
   logic [1:0]  emit_kind;
   rsp_type     res;

   assign req_ready = !div_rsp.busy && !queue_full;
   assign accept    = req_valid && req_ready;
   assign placed    = {24'd0, req_data.file_byte} << {idx_ff[1:0], 3'b000};

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      tag_in       = tag_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      fmt_seen_in  = fmt_seen_ff;
      data_seen_in = data_seen_ff;
      afmt_in      = afmt_ff;
      chans_in     = chans_ff;
      srate_in     = srate_ff;
      brate_in     = brate_ff;
      balign_in    = balign_ff;
      bps_in       = bps_ff;
      dlen_in      = dlen_ff;
      sos_in       = sos_ff;
      limit_in     = limit_ff;
      deflimit_in  = deflimit_ff;
      pleft_in     = pleft_ff;
      idx_in       = idx_ff;
      accepted_in  = accepted_ff;
      accb         = '0;
      fin          = 1'b0;
      fin_status   = ST_OK;
      emit         = 1'b0;
      emit_kind    = EV_FMT;
      res          = '0;
      div_req      = '0;

      if (div_rsp.done) begin
         limit_in = div_rsp.quotient;
      end

      if (accept) begin
         unique case (phase_ff)
            PH_RIFF, PH_WAVE, PH_CID: begin
               tag_in = {req_data.file_byte, tag_ff[31:8]};
               if (idx_ff == 5'd3) begin
                  idx_in = '0;
                  if (phase_ff == PH_RIFF) begin
                     if (tag_in != TAG_RIFF) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_RIFF;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_RSIZE;
                     end
                  end else if (phase_ff == PH_WAVE) begin
                     if (tag_in != TAG_WAVE) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_WAVE;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_CID;
                     end
                  end else begin
                     phase_in = PH_CSIZE;
                     acc_in   = '0;
                  end
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
            PH_RSIZE: begin
               if (idx_ff == 5'd3) begin
                  idx_in   = '0;
                  phase_in = PH_WAVE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
            PH_CSIZE: begin
               acc_in = acc_ff | placed;
               if (idx_ff == 5'd3) begin
                  idx_in   = '0;
                  // odd sizes carry one pad byte
                  left_in  = {1'b0, acc_in} + {32'd0, acc_in[0]};
                  phase_in = PH_SKIP;
                  if (tag_ff == TAG_FMT && acc_in >= 32'd16) begin
                     phase_in = PH_FMT;
                  end else if (tag_ff == TAG_DATA) begin
                     dlen_in      = acc_in;
                     sos_in       = pos_ff + 32'd1;
                     data_seen_in = 1'b1;
                     if (balign_ff == 16'd0) begin
                        limit_in = '1;
                     end else if (!req_data.is_last) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = acc_in;
                        div_req.divisor  = balign_ff;
                     end
                     if (fmt_seen_ff) begin
                        fin        = 1'b1;
                        fin_status = ST_OK;
                        phase_in   = PH_DONE;
                     end else begin
                        emit      = 1'b1;
                        emit_kind = EV_DATA;
                     end
                  end else if (tag_ff == TAG_CUE) begin
                     phase_in    = PH_CUEN;
                     acc_in      = '0;
                     accepted_in = '0;
                  end
                  if (phase_in != PH_DONE && left_in == 33'd0) begin
                     phase_in = PH_CID;
                  end
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
            PH_FMT, PH_CUEN, PH_CUEP, PH_SKIP: begin
               left_in = left_ff - 33'd1;
               if (phase_ff == PH_FMT) begin
                  accb   = ((idx_ff[1:0] == 2'd0) ? 32'd0 : acc_ff) | placed;
                  acc_in = accb;
                  case (idx_ff)
                     5'd1:    afmt_in   = accb[15:0];
                     5'd3:    chans_in  = accb[31:16];
                     5'd7:    srate_in  = accb;
                     5'd11:   brate_in  = accb;
                     5'd13:   balign_in = accb[15:0];
                     5'd15:   bps_in    = accb[31:16];
                     default: ;
                  endcase
                  if (idx_ff == 5'd15) begin
                     idx_in      = '0;
                     fmt_seen_in = 1'b1;
                     phase_in    = PH_SKIP;
                     if (data_seen_ff) begin
                        fin        = 1'b1;
                        fin_status = ST_OK;
                        phase_in   = PH_DONE;
                     end else begin
                        emit      = 1'b1;
                        emit_kind = EV_FMT;
                     end
                  end else begin
                     idx_in = idx_ff + 5'd1;
                  end
               end else if (phase_ff == PH_CUEN) begin
                  acc_in = acc_ff | placed;
                  if (idx_ff == 5'd3) begin
                     idx_in = '0;
                     if (acc_in > 32'(MAX_CUES)) begin
                        pleft_in = 6'(MAX_CUES);
                     end else begin
                        pleft_in = acc_in[5:0];
                     end
                     phase_in = (pleft_in != 6'd0) ? PH_CUEP : PH_SKIP;
                  end else begin
                     idx_in = idx_ff + 5'd1;
                  end
               end else if (phase_ff == PH_CUEP) begin
                  // only the sample offset, bytes 20 to 23 of a point, matters
                  if (idx_ff >= 5'd20) begin
                     acc_in = ((idx_ff == 5'd20) ? 32'd0 : acc_ff) | placed;
                  end
                  if (idx_ff >= 5'd23) begin
                     idx_in = '0;
                     if (acc_in < limit_ff) begin
                        accepted_in = accepted_ff + 6'd1;
                        emit        = 1'b1;
                        emit_kind   = EV_CUE;
                     end
                     pleft_in = (pleft_ff != 6'd0) ? pleft_ff - 6'd1 : 6'd0;
                     if (pleft_in == 6'd0) begin
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     idx_in = idx_ff + 5'd1;
                  end
               end
               if (phase_in != PH_DONE && left_in == 33'd0) begin
                  phase_in = PH_CID;
                  idx_in   = '0;
               end
            end
            PH_DONE: ;
            default: ;
         endcase

         pos_in = pos_ff + 32'd1;

         if (req_data.is_last && phase_in != PH_DONE) begin
            fin = 1'b1;
            if (phase_in == PH_RIFF || phase_in == PH_RSIZE || phase_in == PH_WAVE) begin
               fin_status = ST_NOT_RIFF;
            end else begin
               fin_status = ST_MISSING;
            end
         end

         if (fin) begin
            res.event_kind      = EV_FINISH;
            res.audio_format    = afmt_in;
            res.channel_count   = chans_in;
            res.sample_rate     = srate_in;
            res.byte_rate       = brate_in;
            res.block_align     = balign_in;
            res.bits_per_sample = bps_in;
            res.data_size       = dlen_in;
            res.header_length   = sos_in;
            res.cue_count       = accepted_in;
            res.status          = fin_status;
            phase_in            = PH_DONE;
         end else if (emit) begin
            res.event_kind = emit_kind;
            case (emit_kind)
               EV_FMT: begin
                  res.audio_format    = afmt_in;
                  res.channel_count   = chans_in;
                  res.sample_rate     = srate_in;
                  res.byte_rate       = brate_in;
                  res.block_align     = balign_in;
                  res.bits_per_sample = bps_in;
               end
               EV_DATA: begin
                  res.data_size     = dlen_in;
                  res.header_length = sos_in;
               end
               default: begin
                  res.cue_offset = acc_in;
                  res.cue_count  = accepted_in;
               end
            endcase
         end

         // last byte rearms for the next file, register kept
         if (req_data.is_last) begin
            phase_in     = PH_RIFF;
            pos_in       = '0;
            tag_in       = '0;
            acc_in       = '0;
            left_in      = '0;
            fmt_seen_in  = 1'b0;
            data_seen_in = 1'b0;
            afmt_in      = '0;
            chans_in     = '0;
            srate_in     = '0;
            brate_in     = '0;
            balign_in    = '0;
            bps_in       = '0;
            dlen_in      = '0;
            sos_in       = '0;
            limit_in     = deflimit_ff;
            pleft_in     = '0;
            idx_in       = '0;
            accepted_in  = '0;
         end
      end

      if (csr_write_enable) begin
         deflimit_in = csr_write_data;
         if (!data_seen_ff) begin
            limit_in = csr_write_data;
         end
      end
   end

   assign push      = accept && (fin || emit);
   assign push_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         pos_ff       <= '0;
         tag_ff       <= '0;
         acc_ff       <= '0;
         left_ff      <= '0;
         fmt_seen_ff  <= 1'b0;
         data_seen_ff <= 1'b0;
         afmt_ff      <= '0;
         chans_ff     <= '0;
         srate_ff     <= '0;
         brate_ff     <= '0;
         balign_ff    <= '0;
         bps_ff       <= '0;
         dlen_ff      <= '0;
         sos_ff       <= '0;
         limit_ff     <= '1;
         deflimit_ff  <= '1;
         pleft_ff     <= '0;
         idx_ff       <= '0;
         accepted_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         tag_ff       <= tag_in;
         acc_ff       <= acc_in;
         left_ff      <= left_in;
         fmt_seen_ff  <= fmt_seen_in;
         data_seen_ff <= data_seen_in;
         afmt_ff      <= afmt_in;
         chans_ff     <= chans_in;
         srate_ff     <= srate_in;
         brate_ff     <= brate_in;
         balign_ff    <= balign_in;
         bps_ff       <= bps_in;
         dlen_ff      <= dlen_in;
         sos_ff       <= sos_in;
         limit_ff     <= limit_in;
         deflimit_ff  <= deflimit_in;
         pleft_ff     <= pleft_in;
         idx_ff       <= idx_in;
         accepted_ff  <= accepted_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wav_riff_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// Byte-serial RIFF/WAVE header parser reporting fmt, data, cue and status items.
// ----------------------------------------------------------------------------
//  port group   direction   handshake          payload
//  req_*        in          req_valid/ready    req_type  (file byte, last flag)
//  rsp_*        out         rsp_valid/ready    rsp_type  (event fields)
//  csr_*        in          csr_write_enable   32-bit default cue limit
//
//  one byte is taken per cycle while the two-entry result queue has room and no divide runs
//  a data chunk with nonzero block align runs a serial divide for the cue
//  limit; input is held off until that divide is done
//  reset is synchronous and active high; no clearing pass is needed
//  a stalled result side holds off input once the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module wav_riff_header_parser
   import wrhp_pkg::*;
#(
   parameter int MAX_CUES = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   logic        queue_full;
   logic        push;
   rsp_type     push_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   wrhp_front #(
      .MAX_CUES(MAX_CUES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .queue_full      (queue_full),
      .push            (push),
      .push_data       (push_data),
      .div_req         (div_req),
      .div_rsp         (div_rsp)
   );

   wrhp_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   wrhp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (queue_full),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
